### rtl/bds_pkg.sv
// Shared constants, payload words, controller commands and helpers for the deposition surface.
package bds_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MIN_COLUMNS = 3;
    localparam int HEIGHT_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int N_BITS      = $clog2(MAX_COLUMNS + 1);
    localparam int CFG_BITS    = 11;
    localparam int FRAC_BITS   = 8;
    localparam int OUT_BITS    = 24;

    localparam int SUM_BITS    = HEIGHT_BITS + COL_BITS;
    localparam int SQ_BITS     = 2 * HEIGHT_BITS + COL_BITS;
    localparam int SQ_LO_BITS  = SQ_BITS / 2;
    localparam int SQ_HI_BITS  = SQ_BITS - SQ_LO_BITS;
    localparam int NSQ_BITS    = N_BITS + SQ_BITS;
    localparam int RAD_BITS    = ((NSQ_BITS + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_BITS   = RAD_BITS / 2;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int DIVD_BITS   = ROOT_BITS;
    localparam int STEP_BITS   = $clog2(ROOT_BITS + 1);

    localparam logic REQ_DEPOSIT = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = {HEIGHT_BITS{1'b1}};

    typedef struct packed {
        logic                req_type;
        logic [COL_BITS-1:0] column;
        logic                report;
    } in_word_t;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] column_height;
        logic [OUT_BITS-1:0]    mean_height;
        logic [OUT_BITS-1:0]    roughness;
        logic                   report_valid;
        logic                   height_saturated;
        logic                   bad_column;
    } out_word_t;

    typedef enum logic [1:0] {
        ADDR_COL,
        ADDR_LEFT,
        ADDR_RIGHT
    } addr_sel_t;

    typedef enum logic [4:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DECODE,
        ST_RD_L,
        ST_RD_R,
        ST_UPD,
        ST_SQ,
        ST_ACC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_NSQ,
        ST_DIFF,
        ST_SQRT,
        ST_DM_INIT,
        ST_DM,
        ST_DR_INIT,
        ST_DR,
        ST_OUT,
        ST_CLR_OUT
    } state_t;

    typedef struct packed {
        logic      accept;
        logic      sweep_start;
        logic      sweep_step;
        addr_sel_t addr_sel;
        logic      cap_old;
        logic      cap_left;
        logic      upd_write;
        logic      sq_mul;
        logic      acc_update;
        logic      mul_lo;
        logic      mul_hi;
        logic      nsq_add;
        logic      sqrt_start;
        logic      sqrt_step;
        logic      div_start_mean;
        logic      div_start_rough;
        logic      cap_mean;
        logic      div_step;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_bad;
        logic want_report;
        logic sweep_done;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic [OUT_BITS-1:0] sat_out(input logic [DIVD_BITS-1:0] v);
        logic [OUT_BITS-1:0] r;
        if (|v[DIVD_BITS-1:OUT_BITS])
            r = {OUT_BITS{1'b1}};
        else
            r = v[OUT_BITS-1:0];
        return r;
    endfunction

endpackage

### rtl/bds_ram.sv
// Generic simple dual-port RAM with registered read.
module bds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bds_datapath.sv
// Datapath: height store, running sums, multipliers, square root and divider units, output word.
module bds_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bds_pkg::cmd_t             cmd,
    output bds_pkg::sts_t             sts,
    input  bds_pkg::in_word_t         in_data,
    input  logic                      cfg_we,
    input  logic [bds_pkg::CFG_BITS-1:0] cfg_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output bds_pkg::out_word_t        out_data
);
    import bds_pkg::*;

    logic [N_BITS-1:0]          n_reg;
    logic [N_BITS-1:0]          n_next;
    in_word_t                   in_reg;
    logic [HEIGHT_BITS-1:0]     old_reg;
    logic [HEIGHT_BITS-1:0]     left_reg;
    logic [HEIGHT_BITS-1:0]     newh_reg;
    logic                       sat_reg;
    logic [2*HEIGHT_BITS-1:0]   sqn_reg;
    logic [2*HEIGHT_BITS-1:0]   sqo_reg;
    logic [SUM_BITS-1:0]        sum_reg;
    logic [SQ_BITS-1:0]         sq_reg;
    logic [N_BITS+SQ_LO_BITS-1:0] plo_reg;
    logic [N_BITS+SQ_HI_BITS-1:0] phi_reg;
    logic [2*SUM_BITS-1:0]      ssq_reg;
    logic [NSQ_BITS-1:0]        nsq_reg;
    logic [RAD_BITS-1:0]        rad_reg;
    logic [ROOT_BITS-1:0]       root_reg;
    logic [REM_BITS-1:0]        srem_reg;
    logic [STEP_BITS-1:0]       sq_cnt_reg;
    logic [DIVD_BITS-1:0]       quo_reg;
    logic [N_BITS-1:0]          drem_reg;
    logic [STEP_BITS-1:0]       div_cnt_reg;
    logic [OUT_BITS-1:0]        mean_reg;
    logic [N_BITS-1:0]          sweep_cnt_reg;
    out_word_t                  out_reg;
    out_word_t                  out_next;
    logic                       out_valid_reg;

    logic [COL_BITS-1:0]        col;
    logic [N_BITS-1:0]          n_m1;
    logic [COL_BITS-1:0]        left_col;
    logic [COL_BITS-1:0]        right_col;
    logic                       is_bad;
    logic                       is_clear;
    logic [COL_BITS-1:0]        raddr;
    logic [COL_BITS-1:0]        waddr;
    logic [HEIGHT_BITS-1:0]     wdata;
    logic                       mem_we;
    logic [HEIGHT_BITS-1:0]     rdata;

    logic                       col_sat;
    logic [HEIGHT_BITS-1:0]     inc_h;
    logic [HEIGHT_BITS-1:0]     max_lo;
    logic [HEIGHT_BITS-1:0]     newh;

    logic [NSQ_BITS-1:0]        diff;
    logic [REM_BITS-1:0]        srem_sh;
    logic [REM_BITS-1:0]        trial;
    logic                       sq_take;
    logic [N_BITS:0]            drem_sh;
    logic                       div_take;

    // Ring size is held in the range the store supports
    always_comb
    begin
        if (cfg_data < CFG_BITS'(MIN_COLUMNS))
            n_next = N_BITS'(MIN_COLUMNS);
        else if (cfg_data > CFG_BITS'(MAX_COLUMNS))
            n_next = N_BITS'(MAX_COLUMNS);
        else
            n_next = N_BITS'(cfg_data);
    end

    assign col       = in_reg.column;
    assign n_m1      = n_reg - N_BITS'(1);
    assign is_clear  = (in_reg.req_type == REQ_CLEAR);
    assign is_bad    = ({1'b0, col} >= n_reg);
    assign left_col  = (col == '0) ? n_m1[COL_BITS-1:0] : col - COL_BITS'(1);
    assign right_col = ({1'b0, col} == n_m1) ? '0 : col + COL_BITS'(1);

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_COL:   raddr = col;
            ADDR_LEFT:  raddr = left_col;
            ADDR_RIGHT: raddr = right_col;
            default:    raddr = col;
        endcase
    end

    // New height: own height plus one, held at the top, raised to the taller neighbour
    assign col_sat = (old_reg == HEIGHT_MAX);
    assign inc_h   = col_sat ? HEIGHT_MAX : old_reg + HEIGHT_BITS'(1);
    assign max_lo  = (left_reg > inc_h) ? left_reg : inc_h;
    assign newh    = (rdata > max_lo) ? rdata : max_lo;

    assign mem_we = cmd.upd_write | cmd.sweep_step;
    assign waddr  = cmd.upd_write ? col : sweep_cnt_reg[COL_BITS-1:0];
    assign wdata  = cmd.upd_write ? newh : '0;

    bds_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // n*sum2 - sum^2, never negative while the sums cover only the columns in use
    assign diff = nsq_reg - NSQ_BITS'(ssq_reg);

    assign srem_sh = {srem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign sq_take = (srem_sh >= trial);

    assign drem_sh  = {drem_reg, quo_reg[DIVD_BITS-1]};
    assign div_take = (drem_sh >= {1'b0, n_reg});

    // Control and accumulated state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= N_BITS'(MAX_COLUMNS);
            sum_reg       <= '0;
            sq_reg        <= '0;
            sweep_cnt_reg <= '0;
            sq_cnt_reg    <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                n_reg <= n_next;
            end

            if (cmd.sweep_start)
            begin
                sweep_cnt_reg <= '0;
                sum_reg       <= '0;
                sq_reg        <= '0;
            end
            else
            begin
                if (cmd.sweep_step)
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + N_BITS'(1);
                end
                if (cmd.acc_update)
                begin
                    sum_reg <= sum_reg + SUM_BITS'(newh_reg) - SUM_BITS'(old_reg);
                    sq_reg  <= sq_reg + SQ_BITS'(sqn_reg) - SQ_BITS'(sqo_reg);
                end
            end

            if (cmd.sqrt_start)
                sq_cnt_reg <= STEP_BITS'(ROOT_BITS);
            else if (cmd.sqrt_step)
                sq_cnt_reg <= sq_cnt_reg - STEP_BITS'(1);

            if (cmd.div_start_mean || cmd.div_start_rough)
                div_cnt_reg <= STEP_BITS'(DIVD_BITS);
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - STEP_BITS'(1);

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        out_next                  = out_reg;
        out_next.column_height    = newh_reg;
        out_next.report_valid     = in_reg.report;
        out_next.height_saturated = sat_reg;
        out_next.bad_column       = is_bad && !is_clear;
        if (in_reg.report && !is_clear)
        begin
            out_next.mean_height = mean_reg;
            out_next.roughness   = sat_out(quo_reg);
        end
        else
        begin
            out_next.mean_height = '0;
            out_next.roughness   = '0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_reg   <= in_data;
            newh_reg <= '0;
            sat_reg  <= 1'b0;
        end
        if (cmd.cap_old)
            old_reg <= rdata;
        if (cmd.cap_left)
            left_reg <= rdata;
        if (cmd.upd_write)
        begin
            newh_reg <= newh;
            sat_reg  <= col_sat;
        end
        if (cmd.sq_mul)
        begin
            sqn_reg <= newh_reg * newh_reg;
            sqo_reg <= old_reg * old_reg;
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= n_reg * sq_reg[SQ_LO_BITS-1:0];
            ssq_reg <= sum_reg * sum_reg;
        end
        if (cmd.mul_hi)
            phi_reg <= n_reg * sq_reg[SQ_BITS-1:SQ_LO_BITS];
        if (cmd.nsq_add)
            nsq_reg <= NSQ_BITS'({phi_reg, {SQ_LO_BITS{1'b0}}}) + NSQ_BITS'(plo_reg);

        // Square root: two radicand bits per step
        if (cmd.sqrt_start)
        begin
            rad_reg  <= RAD_BITS'({diff, {(2*FRAC_BITS){1'b0}}});
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[RAD_BITS-3:0], 2'b00};
            if (sq_take)
            begin
                srem_reg <= srem_sh - trial;
                root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
            end
        end

        // Divider by the ring size: one quotient bit per step
        if (cmd.cap_mean)
            mean_reg <= sat_out(quo_reg);
        if (cmd.div_start_mean)
        begin
            quo_reg  <= DIVD_BITS'({sum_reg, {FRAC_BITS{1'b0}}});
            drem_reg <= '0;
        end
        else if (cmd.div_start_rough)
        begin
            quo_reg  <= DIVD_BITS'(root_reg);
            drem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_take)
            begin
                drem_reg <= N_BITS'(drem_sh - {1'b0, n_reg});
                quo_reg  <= {quo_reg[DIVD_BITS-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= drem_sh[N_BITS-1:0];
                quo_reg  <= {quo_reg[DIVD_BITS-2:0], 1'b0};
            end
        end

        if (cmd.out_load)
            out_reg <= out_next;
    end

    assign sts.is_clear    = is_clear;
    assign sts.is_bad      = is_bad;
    assign sts.want_report = in_reg.report;
    assign sts.sweep_done  = (sweep_cnt_reg == N_BITS'(MAX_COLUMNS));
    assign sts.sqrt_done   = (sq_cnt_reg == '0);
    assign sts.div_done    = (div_cnt_reg == '0);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_sqrt_step_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_step |-> sq_cnt_reg != '0)
        else $error("square root stepped past its last bit");

    a_div_step_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> div_cnt_reg != '0)
        else $error("divider stepped past its last bit");

    a_write_good_col: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_write |-> !is_bad && !is_clear)
        else $error("height written for a bad column or a clear word");

    a_sum_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_update && !cmd.sweep_start |=> sum_reg >= $past(sum_reg))
        else $error("height sum fell on a deposit");

endmodule

### rtl/bds_ctrl.sv
// Controller state machine sequencing sweeps, deposits and reports.
module bds_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          cfg_we,
    input  bds_pkg::sts_t sts,
    output logic          in_stall,
    output bds_pkg::cmd_t cmd
);
    import bds_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SWEEP;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            state_next = ST_SWEEP;
        end
        else
        begin
            unique case (state_reg)
                ST_SWEEP:   if (sts.sweep_done) state_next = ST_IDLE;
                ST_IDLE:    if (in_valid) state_next = ST_DECODE;
                ST_DECODE:
                begin
                    priority if (sts.is_clear)
                        state_next = ST_CLR_OUT;
                    else if (sts.is_bad)
                        state_next = sts.want_report ? ST_MUL_LO : ST_OUT;
                    else
                        state_next = ST_RD_L;
                end
                ST_RD_L:    state_next = ST_RD_R;
                ST_RD_R:    state_next = ST_UPD;
                ST_UPD:     state_next = ST_SQ;
                ST_SQ:      state_next = ST_ACC;
                ST_ACC:     state_next = sts.want_report ? ST_MUL_LO : ST_OUT;
                ST_MUL_LO:  state_next = ST_MUL_HI;
                ST_MUL_HI:  state_next = ST_NSQ;
                ST_NSQ:     state_next = ST_DIFF;
                ST_DIFF:    state_next = ST_SQRT;
                ST_SQRT:    if (sts.sqrt_done) state_next = ST_DM_INIT;
                ST_DM_INIT: state_next = ST_DM;
                ST_DM:      if (sts.div_done) state_next = ST_DR_INIT;
                ST_DR_INIT: state_next = ST_DR;
                ST_DR:      if (sts.div_done) state_next = ST_OUT;
                ST_OUT:     if (sts.out_free) state_next = ST_IDLE;
                ST_CLR_OUT: if (sts.out_free) state_next = ST_SWEEP;
                default:    state_next = ST_SWEEP;
            endcase
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = ADDR_COL;
        in_stall     = (state_reg != ST_IDLE) || cfg_we;
        if (cfg_we)
        begin
            cmd.sweep_start = 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_SWEEP:   cmd.sweep_step = !sts.sweep_done;
                ST_IDLE:    cmd.accept = in_valid;
                ST_DECODE:  cmd.addr_sel = ADDR_COL;
                ST_RD_L:
                begin
                    cmd.addr_sel = ADDR_LEFT;
                    cmd.cap_old  = 1'b1;
                end
                ST_RD_R:
                begin
                    cmd.addr_sel = ADDR_RIGHT;
                    cmd.cap_left = 1'b1;
                end
                ST_UPD:     cmd.upd_write = 1'b1;
                ST_SQ:      cmd.sq_mul = 1'b1;
                ST_ACC:     cmd.acc_update = 1'b1;
                ST_MUL_LO:  cmd.mul_lo = 1'b1;
                ST_MUL_HI:  cmd.mul_hi = 1'b1;
                ST_NSQ:     cmd.nsq_add = 1'b1;
                ST_DIFF:    cmd.sqrt_start = 1'b1;
                ST_SQRT:    cmd.sqrt_step = !sts.sqrt_done;
                ST_DM_INIT: cmd.div_start_mean = 1'b1;
                ST_DM:      cmd.div_step = !sts.div_done;
                ST_DR_INIT:
                begin
                    cmd.cap_mean        = 1'b1;
                    cmd.div_start_rough = 1'b1;
                end
                ST_DR:      cmd.div_step = !sts.div_done;
                ST_OUT:     cmd.out_load = sts.out_free;
                ST_CLR_OUT:
                begin
                    cmd.out_load    = sts.out_free;
                    cmd.sweep_start = sts.out_free;
                end
                default:    cmd.sweep_start = 1'b1;
            endcase
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result word loaded over one not yet taken");

endmodule

### rtl/ballistic_deposition_surface_core.sv
// Ballistic deposition surface: ring of column heights with mean and roughness reports.
// Deposit: the taken word passes decode, three RAM reads, one write and the sum update before
// its result word is loaded into the output register.
// Report: products, then a 35-step square root and two 35-step divisions by the ring size.
// One word in flight; the next is taken once its result sits in the output register.
// Reset and every clear or ring-size write sweep the 1024-entry RAM, with the input stalled.
module ballistic_deposition_surface_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bds_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bds_pkg::out_word_t           out_data,
    input  logic                         cfg_we,
    input  logic [bds_pkg::CFG_BITS-1:0] cfg_data
);
    import bds_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cfg_we   (cfg_we),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    bds_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
